[src/scrw_pkg.sv]
// shared types and codes for the sccb register write master
`timescale 1ns / 1ps

package scrw_pkg;

    // sequencer phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_BIT   = 3'd2;
    localparam logic [2:0] PH_ACK   = 3'd3;
    localparam logic [2:0] PH_STOP  = 3'd4;

    // opcodes of an input item
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // register indexes on the config port
    localparam logic REG_DEVICE_ADDRESS = 1'b0;
    localparam logic REG_MAX_ATTEMPTS   = 1'b1;

    // register reset values
    localparam logic [7:0] DEVICE_ADDRESS_RST = 8'h42;
    localparam logic [4:0] MAX_ATTEMPTS_RST   = 5'd20;

    // byte_select value of the last byte (value byte)
    localparam logic [1:0] LAST_BYTE = 2'd2;
    // bit_count of the lsb
    localparam logic [2:0] LAST_BIT  = 3'd7;

    typedef struct packed {
        logic [7:0] device_address;
        logic [4:0] max_attempts;
    } t_cfg;

    typedef struct packed {
        logic       opcode;
        logic [7:0] reg_address;
        logic [7:0] reg_value;
        logic       sda_sample;
    } t_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic       failed;
        logic [4:0] attempts_used;
    } t_result;

endpackage

[src/scrw_cfg_regs.sv]
// apb-style configuration registers: device address and attempt limit
`timescale 1ns / 1ps

module scrw_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output scrw_pkg::t_cfg     o_cfg
);
    import scrw_pkg::*;

    logic [7:0] r_device_address;
    logic [4:0] r_max_attempts;
    logic       wr_en;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= DEVICE_ADDRESS_RST;
            r_max_attempts   <= MAX_ATTEMPTS_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_DEVICE_ADDRESS: r_device_address <= pwdata[7:0];
                REG_MAX_ATTEMPTS:   r_max_attempts   <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_DEVICE_ADDRESS: prdata = {24'd0, r_device_address};
            REG_MAX_ATTEMPTS:   prdata = {27'd0, r_max_attempts};
            default:            prdata = 32'd0;
        endcase
    end

    assign o_cfg.device_address = r_device_address;
    assign o_cfg.max_attempts   = r_max_attempts;

endmodule

[src/scrw_seq.sv]
// transfer sequencer: phase, bit and step counters, shifter, retry count
`timescale 1ns / 1ps

module scrw_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  scrw_pkg::t_item    i_item,
    input  scrw_pkg::t_cfg     i_cfg,
    output scrw_pkg::t_result  o_result
);
    import scrw_pkg::*;

    logic [2:0] r_phase,    n_phase;
    logic [1:0] r_bsel,     n_bsel;
    logic [2:0] r_bit_cnt,  n_bit_cnt;
    logic [1:0] r_sub,      n_sub;
    logic [7:0] r_shift,    n_shift;
    logic [4:0] r_attempt,  n_attempt;
    logic [7:0] r_held_addr, n_held_addr;
    logic [7:0] r_held_val,  n_held_val;
    logic       r_nack,     n_nack;
    logic       r_failed,   n_failed;
    logic       r_scl,      n_scl;
    logic       r_sda,      n_sda;
    logic       done;
    logic       tx_bit;
    logic [4:0] limit;

    assign tx_bit = r_shift[7];
    assign limit  = (i_cfg.max_attempts == 5'd0) ? 5'd1 : i_cfg.max_attempts;

    always_comb begin
        n_phase     = r_phase;
        n_bsel      = r_bsel;
        n_bit_cnt   = r_bit_cnt;
        n_sub       = r_sub;
        n_shift     = r_shift;
        n_attempt   = r_attempt;
        n_held_addr = r_held_addr;
        n_held_val  = r_held_val;
        n_nack      = r_nack;
        n_failed    = r_failed;
        n_scl       = r_scl;
        n_sda       = r_sda;
        done        = 1'b0;

        if (i_item.opcode == OP_WRITE) begin
            // command is taken only when idle, lines untouched
            if (r_phase == PH_IDLE) begin
                n_held_addr = i_item.reg_address;
                n_held_val  = i_item.reg_value;
                n_attempt   = 5'd1;
                n_failed    = 1'b0;
                n_nack      = 1'b0;
                n_bsel      = 2'd0;
                n_bit_cnt   = 3'd0;
                n_sub       = 2'd0;
                n_phase     = PH_START;
            end
        end else begin
            case (r_phase)
                PH_START: begin
                    if (r_sub == 2'd0) begin
                        n_scl = 1'b1; n_sda = 1'b1;
                        n_sub = 2'd1;
                    end else begin
                        n_scl     = 1'b1; n_sda = 1'b0;
                        n_phase   = PH_BIT;
                        n_bsel    = 2'd0;
                        n_bit_cnt = 3'd0;
                        n_sub     = 2'd0;
                        n_shift   = i_cfg.device_address;
                    end
                end
                PH_BIT: begin
                    n_sda = tx_bit;
                    if (r_sub == 2'd0) begin
                        n_scl = 1'b0;
                        n_sub = 2'd1;
                    end else if (r_sub == 2'd1) begin
                        n_scl = 1'b1;
                        n_sub = 2'd2;
                    end else begin
                        n_scl   = 1'b0;
                        n_shift = {r_shift[6:0], 1'b0};
                        n_sub   = 2'd0;
                        if (r_bit_cnt == LAST_BIT) begin
                            n_bit_cnt = 3'd0;
                            n_phase   = PH_ACK;
                        end else begin
                            n_bit_cnt = r_bit_cnt + 3'd1;
                        end
                    end
                end
                PH_ACK: begin
                    n_sda = 1'b1;
                    if (r_sub == 2'd0) begin
                        n_scl = 1'b0;
                        n_sub = 2'd1;
                    end else if (r_sub == 2'd1) begin
                        // slave acknowledge sampled with scl high
                        n_scl  = 1'b1;
                        n_nack = i_item.sda_sample;
                        n_sub  = 2'd2;
                    end else begin
                        n_scl = 1'b0;
                        n_sub = 2'd0;
                        if (r_nack || r_bsel >= LAST_BYTE) begin
                            n_phase = PH_STOP;
                        end else begin
                            n_bsel  = r_bsel + 2'd1;
                            n_shift = (r_bsel == 2'd0) ? r_held_addr : r_held_val;
                            n_phase = PH_BIT;
                        end
                    end
                end
                PH_STOP: begin
                    if (r_sub == 2'd0) begin
                        n_scl = 1'b0; n_sda = 1'b0;
                        n_sub = 2'd1;
                    end else if (r_sub == 2'd1) begin
                        n_scl = 1'b1; n_sda = 1'b0;
                        n_sub = 2'd2;
                    end else begin
                        n_scl = 1'b1; n_sda = 1'b1;
                        n_sub = 2'd0;
                        if (!r_nack) begin
                            n_failed = 1'b0;
                            n_phase  = PH_IDLE;
                            done     = 1'b1;
                        end else if (r_attempt >= limit) begin
                            n_failed = 1'b1;
                            n_phase  = PH_IDLE;
                            done     = 1'b1;
                        end else begin
                            n_attempt = r_attempt + 5'd1;
                            n_nack    = 1'b0;
                            n_phase   = PH_START;
                        end
                    end
                end
                default: begin
                    n_scl = 1'b1; n_sda = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bsel    <= 2'd0;
            r_bit_cnt <= 3'd0;
            r_sub     <= 2'd0;
            r_shift   <= 8'd0;
            r_attempt <= 5'd0;
            r_nack    <= 1'b0;
            r_failed  <= 1'b0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
        end else if (i_advance) begin
            r_phase   <= n_phase;
            r_bsel    <= n_bsel;
            r_bit_cnt <= n_bit_cnt;
            r_sub     <= n_sub;
            r_shift   <= n_shift;
            r_attempt <= n_attempt;
            r_nack    <= n_nack;
            r_failed  <= n_failed;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
        end
    end

    // held bytes are written by a command before any read
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_held_addr <= n_held_addr;
            r_held_val  <= n_held_val;
        end
    end

    assign o_result.scl_level     = n_scl;
    assign o_result.sda_level     = n_sda;
    assign o_result.busy_res      = (n_phase != PH_IDLE);
    assign o_result.done_res      = done;
    assign o_result.failed        = n_failed;
    assign o_result.attempts_used = n_attempt;

    a_bitcnt_only_in_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bit_cnt != 3'd0) |-> (r_phase == PH_BIT))
        else $error("bit counter running outside bit phase");

    a_busy_not_failed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> !r_failed)
        else $error("failed flag set during a transfer");

    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_scl && r_sda))
        else $error("bus not released while idle");

endmodule

[src/sccb_register_write_master.sv]
// top level of the sccb three-phase register write master
//
//  port group   dir  handshake              payload
//  input item   in   i_in_valid / o_in_stall  i_opcode, i_reg_address, i_reg_value, i_sda_sample
//  result item  out  o_out_valid / i_out_stall  o_scl_level, o_sda_level, o_busy_res,
//                                           o_done_res, o_failed, o_attempts_used
//  config       in   psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// one item per cycle sustained without output stall; each item gives one result after passing
// the input register, then the sequencer update into the result register
// the sequencer advances once per item, so each tick item is one bus wait period
// synchronous active-low reset: sequencer idle, lines released, no items held
// a stalled result register holds its item and back-pressures the input register;
// the input side stalls only when both stages are full
`timescale 1ns / 1ps

module sccb_register_write_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_reg_address,
    input  logic [7:0]  i_reg_value,
    input  logic        i_sda_sample,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_scl_level,
    output logic        o_sda_level,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic        o_failed,
    output logic [4:0]  o_attempts_used,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import scrw_pkg::*;

    t_cfg    cfg;
    t_item   r_item;
    t_result seq_result;
    t_result r_result;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    out_free;
    logic    advance;
    logic    in_accept;

    // register file
    scrw_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // pipeline control: the held item moves on when the result slot frees up
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // input register, payload only
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.opcode      <= i_opcode;
            r_item.reg_address <= i_reg_address;
            r_item.reg_value   <= i_reg_value;
            r_item.sda_sample  <= i_sda_sample;
        end
    end

    // sequencer does one step per advanced item
    scrw_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_item),
        .i_cfg     (cfg),
        .o_result  (seq_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= seq_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_scl_level     = r_result.scl_level;
    assign o_sda_level     = r_result.sda_level;
    assign o_busy_res      = r_result.busy_res;
    assign o_done_res      = r_result.done_res;
    assign o_failed        = r_result.failed;
    assign o_attempts_used = r_result.attempts_used;

    // a done pulse always closes the transfer
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.done_res) |-> !r_result.busy_res)
        else $error("done reported while still busy");

    // an input item waits only behind a full, stalled result slot
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with free result slot");

    // a held item is registered into the result register when the slot is free
    a_item_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_free) |=> r_out_valid)
        else $error("held item not delivered");

endmodule
